[hw/rtl/tct_pkg.sv]
`default_nettype none
package tct_pkg;

  localparam int SLOTS   = 16;
  localparam int SLOT_W  = 4;
  localparam int POS_W   = 5;
  localparam int CNT_W   = 5;

  localparam logic [CNT_W-1:0] SLOT_LIMIT_RST = CNT_W'(10);
  localparam logic [CNT_W-1:0] SLOTS_CNT      = CNT_W'(SLOTS);

  localparam logic [1:0] CMD_BEGIN  = 2'd0;
  localparam logic [1:0] CMD_UPDATE = 2'd1;
  localparam logic [1:0] CMD_END    = 2'd2;
  localparam logic [1:0] CMD_FRAME  = 2'd3;

  localparam logic KIND_ANSWER = 1'b0;
  localparam logic KIND_FRAME  = 1'b1;

  localparam logic [5:0] FLAG_DOWN      = 6'd1;
  localparam logic [5:0] FLAG_UPDATE    = 6'd2;
  localparam logic [5:0] FLAG_UP        = 6'd4;
  localparam logic [5:0] FLAG_INRANGE   = 6'd8;
  localparam logic [5:0] FLAG_INCONTACT = 6'd16;

  localparam logic [5:0] FLAGS_BEGIN  = FLAG_DOWN | FLAG_INRANGE | FLAG_INCONTACT;
  localparam logic [5:0] FLAGS_MOVE   = FLAG_UPDATE | FLAG_INRANGE | FLAG_INCONTACT;
  localparam logic [5:0] FLAGS_END    = FLAG_UP;

  localparam logic ADDR_SLOT_LIMIT = 1'b0;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic               walk;
    logic               clr;
    logic [1:0]         cmd;
    logic signed [31:0] id;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } cell_cmd_t;

  // what the cell holding the token reports
  typedef struct packed {
    logic               hit;
    logic               emit;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [5:0]         flags;
  } cell_stat_t;

endpackage
`default_nettype wire

[hw/rtl/tct_cell.sv]
`default_nettype none
module tct_cell
  import tct_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       tok_in,
  output logic            tok_out,
  input  wire cell_cmd_t  bc,
  output cell_stat_t      stat
);

  logic               tok;
  logic               active;
  logic               dirty;
  logic signed [31:0] owner;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [5:0]         flags;

  logic act;
  logic hit;
  logic emit;
  logic [5:0] eflags;

  assign act  = tok & bc.walk;
  always_comb begin
    case (bc.cmd)
      CMD_BEGIN:  hit = act & ~active;
      CMD_UPDATE: hit = act & active & (owner == bc.id);
      CMD_END:    hit = act & active & (owner == bc.id);
      default:    hit = 1'b0;
    endcase
  end
  assign emit   = act & (bc.cmd == CMD_FRAME) & (dirty | active);
  // a clean active down contact is repeated as an update
  assign eflags = (!dirty && flags[0]) ? FLAGS_MOVE : flags;

  // cells without the token drive zeros so the row can be or-ed together
  assign tok_out    = tok;
  assign stat.hit   = hit;
  assign stat.emit  = emit;
  assign stat.x     = act ? pos_x : '0;
  assign stat.y     = act ? pos_y : '0;
  assign stat.flags = act ? eflags : '0;

  always_ff @(posedge clk) begin
    if (rst || bc.clr) begin
      tok <= 1'b0;
    end else begin
      tok <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      dirty  <= 1'b0;
    end else if (hit) begin
      dirty <= 1'b1;
      if (bc.cmd == CMD_BEGIN) begin
        active <= 1'b1;
      end else if (bc.cmd == CMD_END) begin
        active <= 1'b0;
      end
    end else if (emit) begin
      dirty <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      pos_x <= bc.x;
      pos_y <= bc.y;
      case (bc.cmd)
        CMD_BEGIN: begin
          owner <= bc.id;
          flags <= FLAGS_BEGIN;
        end
        CMD_UPDATE: flags <= FLAGS_MOVE;
        default: begin
          owner <= '0;
          flags <= FLAGS_END;
        end
      endcase
    end else if (emit) begin
      flags <= eflags;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/touch_contact_slot_tracker.sv]
// touch contact slot tracker
// a command word (cmd, external_id, x, y, time_ms) is taken when start is high
// and busy is low. the slots sit in a row of cells and a token walks that row,
// one cell per clock, from slot 0 up to the number of slots in use.
// begin, update and end stop the walk at the first cell that takes the word and
// give one answer word (kind 0, last 1); the answer is registered and follows the
// matching cell, or the end of the walk over all n slots when nothing matches,
// n being the slot limit register capped at 16.
// a frame tick always walks all n slots and gives one frame word (kind 1) per
// dirty or active slot; each word is held back until the next such slot or the
// end of the walk, so the last one shows when the walk ends and carries last.
// busy stays high until the walk ends, so no new command word is taken mid-walk.
// every result word is valid for exactly one cycle while res_valid is high;
// the receiver cannot stall the block.
// the slot limit sits at byte address 0 of the apb port and resets to 10.
// reset clears every slot, the frame time and the first-frame mark at once.
`default_nettype none
module touch_contact_slot_tracker
  import tct_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         cmd,
  input  wire logic signed [31:0] external_id,
  input  wire logic signed [15:0] x,
  input  wire logic signed [15:0] y,
  input  wire logic [31:0]        time_ms,
  output logic                    res_valid,
  output logic                    kind,
  output logic                    found,
  output logic [SLOT_W-1:0]       slot,
  output logic signed [15:0]      out_x,
  output logic signed [15:0]      out_y,
  output logic [5:0]              contact_flags,
  output logic [31:0]             frame_offset,
  output logic                    last
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  logic               state;
  logic [POS_W-1:0]   pos;
  logic [CNT_W-1:0]   slot_limit;
  logic [CNT_W-1:0]   n_use;
  logic [1:0]         cur_cmd;
  logic signed [31:0] cur_id;
  logic signed [15:0] cur_x;
  logic signed [15:0] cur_y;
  logic [31:0]        cur_time;
  logic [31:0]        offset;
  logic [31:0]        prev_frame_time;
  logic               frame_sent_before;

  logic               pend_v;
  logic [SLOT_W-1:0]  pend_slot;
  logic signed [15:0] pend_x;
  logic signed [15:0] pend_y;
  logic [5:0]         pend_flags;

  logic               accept;
  logic               walking;
  logic               at_end;
  logic               finish;
  logic               any_hit;
  logic               any_emit;
  cell_stat_t         sel;
  cell_cmd_t          bc;
  cell_stat_t         stat [SLOTS];
  logic [SLOTS-1:0]   tok;

  assign accept  = start && !busy;
  assign busy    = (state == S_WALK);
  assign n_use   = (slot_limit > SLOTS_CNT) ? SLOTS_CNT : slot_limit;
  assign at_end  = (state == S_WALK) && (pos == n_use);
  assign walking = (state == S_WALK) && (pos < n_use);
  assign finish  = at_end || (any_hit && (cur_cmd != CMD_FRAME));

  assign bc.walk = walking;
  assign bc.clr  = finish;
  assign bc.cmd  = cur_cmd;
  assign bc.id   = cur_id;
  assign bc.x    = cur_x;
  assign bc.y    = cur_y;

  // apb register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_SLOT_LIMIT) ? {{(32-CNT_W){1'b0}}, slot_limit} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_limit <= SLOT_LIMIT_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == ADDR_SLOT_LIMIT) begin
      slot_limit <= pwdata[CNT_W-1:0];
    end
  end

  // row of slot cells, the token enters at slot 0 on accept
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic tin;
    if (i == 0) begin : g_head
      assign tin = accept;
    end else begin : g_link
      assign tin = tok[i-1];
    end
    tct_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tin),
      .tok_out (tok[i]),
      .bc      (bc),
      .stat    (stat[i])
    );
  end

  // only the token holder reports, so an or across the row selects it
  always_comb begin
    sel = '0;
    for (int i = 0; i < SLOTS; i++) begin
      sel = sel | stat[i];
    end
  end
  assign any_hit  = sel.hit;
  assign any_emit = sel.emit;

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_cmd  <= cmd;
      cur_id   <= external_id;
      cur_x    <= x;
      cur_y    <= y;
      cur_time <= time_ms;
      offset   <= frame_sent_before ? (time_ms - prev_frame_time) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (any_emit) begin
      pend_slot  <= pos[SLOT_W-1:0];
      pend_x     <= sel.x;
      pend_y     <= sel.y;
      pend_flags <= sel.flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      pos               <= '0;
      pend_v            <= 1'b0;
      prev_frame_time   <= '0;
      frame_sent_before <= 1'b0;
      res_valid         <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      if (accept) begin
        state  <= S_WALK;
        pos    <= '0;
        pend_v <= 1'b0;
      end else if (state == S_WALK) begin
        pos <= pos + POS_W'(1);
        if (finish) begin
          state <= S_IDLE;
        end
        if (cur_cmd != CMD_FRAME) begin
          if (finish) begin
            res_valid <= 1'b1;
          end
        end else if (any_emit) begin
          // hold the newest word back until we know whether it is the last
          res_valid <= pend_v;
          pend_v    <= 1'b1;
        end else if (at_end && pend_v) begin
          res_valid         <= 1'b1;
          pend_v            <= 1'b0;
          prev_frame_time   <= cur_time;
          frame_sent_before <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WALK) begin
      if (cur_cmd != CMD_FRAME) begin
        kind          <= KIND_ANSWER;
        found         <= any_hit;
        slot          <= any_hit ? pos[SLOT_W-1:0] : '0;
        out_x         <= '0;
        out_y         <= '0;
        contact_flags <= '0;
        frame_offset  <= '0;
        last          <= 1'b1;
      end else begin
        kind          <= KIND_FRAME;
        found         <= 1'b1;
        slot          <= pend_slot;
        out_x         <= pend_x;
        out_y         <= pend_y;
        contact_flags <= pend_flags;
        frame_offset  <= offset;
        last          <= !any_emit;
      end
    end
  end

  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(tok))
    else $error("more than one cell holds the token");
  a_idle_no_token: assert property (@(posedge clk) disable iff (rst) !busy |-> tok == '0)
    else $error("token left in the row while idle");
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (pos <= n_use))
    else $error("walk ran past the slots in use");
  a_answer_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && kind == KIND_ANSWER) |-> last)
    else $error("answer word without last");
  a_hit_ends: assert property (@(posedge clk) disable iff (rst)
    (any_hit && cur_cmd != CMD_FRAME) |=> (!busy && res_valid && found))
    else $error("matched slot did not end the walk with an answer");

endmodule
`default_nettype wire

[sim/tb_touch_contact_slot_tracker.sv]
`timescale 1ns / 1ps
module tb_touch_contact_slot_tracker;
  import tct_pkg::*;

  localparam int SETTLE_CYCLES = 24;
  localparam int TAIL_CYCLES   = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam logic [2:0] LIMIT_ADDR = {ADDR_SLOT_LIMIT, 2'b00};

  typedef enum logic [1:0] {W_TOUCH, W_CONFIG, W_QUIESCE} word_op_e;
  typedef enum logic [2:0] {DRV_FETCH, DRV_HOLD, DRV_SETTLE, DRV_SETUP, DRV_ACCESS} drv_state_e;

  typedef struct {
    word_op_e    op;
    logic [1:0]  cmd;
    logic [31:0] id;
    logic [15:0] px;
    logic [15:0] py;
    logic [31:0] now;
    logic [4:0]  limit;
    int          gap;
  } touch_word_t;

  typedef struct packed {
    logic        kind;
    logic        found;
    logic [3:0]  slot_id;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [5:0]  flags;
    logic [31:0] offset;
    logic        is_last;
  } contact_report_t;

  logic clk;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic [1:0] cmd = CMD_BEGIN;
  logic signed [31:0] external_id = '0;
  logic signed [15:0] x = '0;
  logic signed [15:0] y = '0;
  logic [31:0] time_ms = '0;
  logic res_valid;
  logic kind;
  logic found;
  logic [SLOT_W-1:0] slot;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic [5:0] contact_flags;
  logic [31:0] frame_offset;
  logic last;

  touch_contact_slot_tracker DUT (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // stimulus and driver state
  touch_word_t touch_words[$];
  touch_word_t parked_word;
  drv_state_e drv_st = DRV_FETCH;
  int settle_cnt = 0;
  int cur_gap = 0;
  logic [31:0] live_ids[$];
  logic [31:0] clock_ms = 0;
  logic item_taken = 1'b0;
  logic cfg_written = 1'b0;

  // predicted contact table
  logic        in_use[SLOTS];
  logic        pending[SLOTS];
  logic [31:0] owner_id[SLOTS];
  logic [15:0] held_x[SLOTS];
  logic [15:0] held_y[SLOTS];
  logic [5:0]  held_flags[SLOTS];
  logic [4:0]  contact_limit;
  logic [31:0] last_frame_ms;
  logic        framed_once;
  contact_report_t awaited_reports[$];
  int mismatches = 0;
  int cycles = 0;

  task automatic add_touch(input logic [1:0] c, input logic [31:0] id,
                           input logic [15:0] px, input logic [15:0] py,
                           input logic [31:0] now);
    touch_word_t w;
    w.op = W_TOUCH;
    w.cmd = c;
    w.id = id;
    w.px = px;
    w.py = py;
    w.now = now;
    w.limit = '0;
    w.gap = cur_gap;
    touch_words.push_back(w);
  endtask

  task automatic add_control(input word_op_e op, input logic [4:0] limit);
    touch_word_t w;
    w.op = op;
    w.cmd = CMD_BEGIN;
    w.id = '0;
    w.px = '0;
    w.py = '0;
    w.now = '0;
    w.limit = limit;
    w.gap = cur_gap;
    touch_words.push_back(w);
  endtask

  task automatic add_random_touch(input int cap);
    int pick;
    int j;
    logic [31:0] id;
    pick = $urandom_range(99);
    clock_ms = clock_ms + $urandom_range(40);
    if ($urandom_range(29) == 0) clock_ms = $urandom;
    if (pick < 28) begin
      // now and then reuse a live id to build duplicates
      if (live_ids.size() > 0 && $urandom_range(7) == 0)
        id = live_ids[$urandom_range(live_ids.size() - 1)];
      else
        id = $urandom;
      add_touch(CMD_BEGIN, id, 16'($urandom), 16'($urandom), $urandom);
      if (live_ids.size() < cap) live_ids.push_back(id);
    end else if (pick < 58 && live_ids.size() > 0) begin
      id = live_ids[$urandom_range(live_ids.size() - 1)];
      add_touch(CMD_UPDATE, id, 16'($urandom), 16'($urandom), $urandom);
    end else if (pick < 78 && live_ids.size() > 0) begin
      j = $urandom_range(live_ids.size() - 1);
      add_touch(CMD_END, live_ids[j], 16'($urandom), 16'($urandom), $urandom);
      live_ids.delete(j);
    end else if (pick < 92) begin
      add_touch(CMD_FRAME, $urandom, 16'($urandom), 16'($urandom), clock_ms);
    end else begin
      add_touch($urandom_range(1) ? CMD_UPDATE : CMD_END, $urandom,
                16'($urandom), 16'($urandom), $urandom);
    end
  endtask

  task automatic build_stimulus();
    int phase_limit[8] = '{16, 1, 0, 31, 3, 16, 7, 10};
    int cap;
    cur_gap = 37;
    // reset setting of ten slots
    add_touch(CMD_FRAME, 32'd0, 16'd0, 16'd0, 32'd100);
    add_touch(CMD_UPDATE, 32'd5, 16'd1, 16'd1, 32'd0);
    add_touch(CMD_END, 32'd5, 16'd1, 16'd1, 32'd0);
    add_touch(CMD_BEGIN, 32'h8000_0000, 16'h8000, 16'h7FFF, 32'hFFFF_FFFF);
    add_touch(CMD_BEGIN, 32'h7FFF_FFFF, 16'h7FFF, 16'h8000, 32'd0);
    add_touch(CMD_BEGIN, 32'd0, 16'd0, 16'd0, 32'd0);
    add_touch(CMD_BEGIN, 32'h7FFF_FFFF, 16'd1, 16'd2, 32'd0);
    add_touch(CMD_UPDATE, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 32'd0);
    add_touch(CMD_UPDATE, 32'd0, 16'h5555, 16'hAAAA, 32'd0);
    add_touch(CMD_FRAME, 32'd0, 16'd0, 16'd0, 32'hFFFF_FFF0);
    // offset wraps past zero, clean down contacts turn into updates
    add_touch(CMD_FRAME, 32'd0, 16'd0, 16'd0, 32'd5);
    add_touch(CMD_END, 32'h8000_0000, 16'h1234, 16'h4321, 32'd0);
    // fresh begin overwrites the unsent up word
    add_touch(CMD_BEGIN, 32'h0000_1234, 16'h00FF, 16'hFF00, 32'd0);
    add_touch(CMD_FRAME, 32'd0, 16'd0, 16'd0, 32'd30);
    add_touch(CMD_END, 32'h0000_1234, 16'h0F0F, 16'hF0F0, 32'd0);
    add_touch(CMD_FRAME, 32'd0, 16'd0, 16'd0, 32'd60);
    add_touch(CMD_FRAME, 32'd0, 16'd0, 16'd0, 32'd61);
    add_touch(CMD_END, 32'h7FFF_FFFF, 16'd3, 16'd4, 32'd0);
    add_touch(CMD_END, 32'h7FFF_FFFF, 16'd5, 16'd6, 32'd0);
    add_touch(CMD_END, 32'h7FFF_FFFF, 16'd7, 16'd8, 32'd0);
    add_touch(CMD_END, 32'd0, 16'd9, 16'd10, 32'd0);
    add_touch(CMD_FRAME, 32'd0, 16'd0, 16'd0, 32'hFFFF_FFFF);
    add_touch(CMD_FRAME, 32'd0, 16'd0, 16'd0, 32'd0);
    add_touch(CMD_BEGIN, 32'hFFFF_FFFF, 16'h0001, 16'hFFFE, 32'd0);
    live_ids.push_back(32'hFFFF_FFFF);
    clock_ms = 32'd200;
    for (int p = 0; p < 8; p++) begin
      cur_gap = (p < 3) ? 37 : (p < 6) ? 87 : 0;
      add_control(W_CONFIG, 5'(phase_limit[p]));
      cap = (phase_limit[p] > SLOTS) ? SLOTS : phase_limit[p];
      for (int k = 0; k < 55; k++) begin
        if (k == 27 && (p == 1 || p == 4)) add_control(W_QUIESCE, '0);
        add_random_touch(cap);
      end
    end
  endtask

  task automatic reset_tracker();
    for (int i = 0; i < SLOTS; i++) begin
      in_use[i] = 1'b0;
      pending[i] = 1'b0;
      owner_id[i] = '0;
      held_x[i] = '0;
      held_y[i] = '0;
      held_flags[i] = '0;
    end
    contact_limit = SLOT_LIMIT_RST;
    last_frame_ms = '0;
    framed_once = 1'b0;
  endtask

  task automatic stash_contact(input int s, input logic [15:0] px, input logic [15:0] py,
                               input logic [5:0] f);
    held_x[s] = px;
    held_y[s] = py;
    held_flags[s] = f;
    pending[s] = 1'b1;
  endtask

  task automatic apply_touch_word(input logic [1:0] c, input logic [31:0] id,
                                  input logic [15:0] px, input logic [15:0] py,
                                  input logic [31:0] now);
    int n;
    int hit;
    int final_i;
    logic [31:0] gap_ms;
    n = (contact_limit > SLOTS_CNT) ? SLOTS : int'(contact_limit);
    hit = -1;
    if (c == CMD_FRAME) begin
      gap_ms = framed_once ? now - last_frame_ms : 32'd0;
      final_i = -1;
      for (int i = 0; i < n; i++)
        if (pending[i] || in_use[i]) final_i = i;
      for (int i = 0; i < n; i++) begin
        if (!pending[i] && !in_use[i]) continue;
        if (pending[i])
          pending[i] = 1'b0;
        else if ((held_flags[i] & FLAG_DOWN) != '0)
          held_flags[i] = FLAGS_MOVE;
        awaited_reports.push_back('{KIND_FRAME, 1'b1, 4'(i), held_x[i], held_y[i],
                                    held_flags[i], gap_ms, i == final_i});
      end
      // a frame with nothing in it does not count as sent
      if (final_i >= 0) begin
        last_frame_ms = now;
        framed_once = 1'b1;
      end
    end else begin
      if (c == CMD_BEGIN) begin
        for (int i = 0; i < n; i++)
          if (!in_use[i] && hit < 0) hit = i;
        if (hit >= 0) begin
          in_use[hit] = 1'b1;
          owner_id[hit] = id;
          stash_contact(hit, px, py, FLAGS_BEGIN);
        end
      end else begin
        for (int i = 0; i < n; i++)
          if (in_use[i] && owner_id[i] == id && hit < 0) hit = i;
        if (hit >= 0) begin
          if (c == CMD_UPDATE) begin
            stash_contact(hit, px, py, FLAGS_MOVE);
          end else begin
            stash_contact(hit, px, py, FLAGS_END);
            in_use[hit] = 1'b0;
            owner_id[hit] = '0;
          end
        end
      end
      awaited_reports.push_back('{KIND_ANSWER, hit >= 0, (hit >= 0) ? 4'(hit) : 4'd0,
                                  16'd0, 16'd0, 6'd0, 32'd0, 1'b1});
    end
  endtask

  function automatic int field_ok(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic launch_next();
    touch_word_t w;
    if (touch_words.size() == 0) begin
      start <= 1'b0;
      drv_st <= DRV_FETCH;
    end else if (touch_words[0].op != W_TOUCH) begin
      start <= 1'b0;
      parked_word <= touch_words.pop_front();
      settle_cnt <= 0;
      drv_st <= DRV_SETTLE;
    end else if ($urandom_range(99) < touch_words[0].gap) begin
      start <= 1'b0;
      drv_st <= DRV_FETCH;
    end else begin
      w = touch_words.pop_front();
      cmd <= w.cmd;
      external_id <= w.id;
      x <= w.px;
      y <= w.py;
      time_ms <= w.now;
      start <= 1'b1;
      drv_st <= DRV_HOLD;
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      drv_st <= DRV_FETCH;
    end else begin
      case (drv_st)
        DRV_FETCH: launch_next();
        DRV_HOLD: if (item_taken) launch_next();
        DRV_SETTLE: begin
          // a frame with nothing to send leaves no word to wait for
          if (awaited_reports.size() != 0 || busy)
            settle_cnt <= 0;
          else if (settle_cnt < SETTLE_CYCLES)
            settle_cnt <= settle_cnt + 1;
          else if (parked_word.op == W_CONFIG) begin
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= LIMIT_ADDR;
            pwdata <= {27'd0, parked_word.limit};
            drv_st <= DRV_SETUP;
          end else
            drv_st <= DRV_FETCH;
        end
        DRV_SETUP: begin
          penable <= 1'b1;
          drv_st <= DRV_ACCESS;
        end
        DRV_ACCESS: if (cfg_written) begin
          psel <= 1'b0;
          penable <= 1'b0;
          pwrite <= 1'b0;
          drv_st <= DRV_FETCH;
        end
        default: drv_st <= DRV_FETCH;
      endcase
    end
  end

  always @(posedge clk) begin
    contact_report_t want;
    if (rst) begin
      item_taken <= 1'b0;
      cfg_written <= 1'b0;
      reset_tracker();
    end else begin
      item_taken <= start && !busy;
      cfg_written <= psel && penable && pwrite && pready;
      if (res_valid) begin
        if (awaited_reports.size() == 0) begin
          $error("unexpected result word: kind %0d slot %0d", kind, slot);
          mismatches++;
        end else begin
          want = awaited_reports.pop_front();
          mismatches += field_ok("kind", want.kind, kind);
          mismatches += field_ok("found", want.found, found);
          mismatches += field_ok("slot", want.slot_id, slot);
          mismatches += field_ok("out_x", want.pos_x, out_x[15:0]);
          mismatches += field_ok("out_y", want.pos_y, out_y[15:0]);
          mismatches += field_ok("contact_flags", want.flags, contact_flags);
          mismatches += field_ok("frame_offset", want.offset, frame_offset);
          mismatches += field_ok("last", want.is_last, last);
        end
      end
      if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR)
        contact_limit = pwdata[4:0];
      if (start && !busy)
        apply_touch_word(cmd, external_id, x, y, time_ms);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (touch_words.size() != 0 || drv_st != DRV_FETCH || start ||
           awaited_reports.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

[files.f]
hw/rtl/tct_pkg.sv
hw/rtl/tct_cell.sv
hw/rtl/touch_contact_slot_tracker.sv
sim/tb_touch_contact_slot_tracker.sv
